// ===== rtl/lca_pkg.sv =====
// shared types and constants for the link channel admission block
// no dependencies
`default_nettype none

package lca_pkg;

  localparam int CAP_W     = 10;
  localparam int CNT_W     = 32;
  localparam int LINK_W    = 6;
  localparam int CONN_W    = 8;
  localparam int HOP_W     = 4;
  localparam int ROUTE_LEN = 8;
  localparam int RIDX_W    = 3;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // register bank, decoded on the word index
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    KIND_ARRIVAL = 2'd0,
    KIND_DEPART  = 2'd1,
    KIND_REINIT  = 2'd2,
    KIND_NOP     = 2'd3
  } lca_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_COUNT
  } lca_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] blocked;
    logic [CNT_W-1:0] admitted;
  } lca_conn_cnt_t;

endpackage

`default_nettype wire

// ===== rtl/link_channel_admission.sv =====
// link channel admission control: free channel table, call counters, sequencer
// depends on lca_pkg
//
// usage
//   in_*  : one beat per call event. in_tuser = kind (arrival, departure, reinit).
//           in_tdata = conn_id, hop_count, link0..link7 from bit 0 up.
//   out_* : exactly one result beat per input beat, in order: admitted flag,
//           total arrivals, total blocked, per-connection admitted and blocked.
//   cfg_* : apb-style register port, capacity at byte address 0.
// timing
//   the free channel table is a 1r1w synchronous ram, read one hop per cycle.
//   an arrival makes a check pass over its route, then a take pass; a blocked
//   arrival skips the take pass. a departure makes one pass, an unused kind
//   goes straight to its result, and reinit runs the clearing pass over both
//   rams. one event is in flight at a time.
// reset
//   reset runs the same clearing pass before in_tready rises; cfg writes are
//   taken meanwhile.
// stall
//   a finished result is held in the output register; while out_tready is low the
//   block finishes the current event's work but holds its commit until the
//   output register is free, and takes no new beat until then.
`default_nettype none

module link_channel_admission
  import lca_pkg::*;
#(
  parameter int LINKS       = 64,
  parameter int MAX_HOPS    = 8,
  parameter int CONNECTIONS = 256
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input channel
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [IN_DATA_W-1:0]   in_tdata,   // conn_id, hop_count, link0..link7, zero pad
  input  wire  [1:0]             in_tuser,   // kind
  // result channel
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // admitted, total_arrivals, total_blocked,
                                             // conn_admitted, conn_blocked, zero pad
  // configuration port
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire  [CFG_AW-1:0]      cfg_paddr,
  input  wire  [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int LA_W  = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int CA_W  = $clog2(CONNECTIONS);
  localparam int SWEEP = (LINKS > CONNECTIONS) ? LINKS : CONNECTIONS;
  localparam int CLR_W = $clog2(SWEEP);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  lca_state_t state_r, state_nxt;

  lca_kind_t            kind_r;
  logic [CONN_W-1:0]    conn_r;
  logic [HOP_W-1:0]     hops_r;
  logic [LINK_W-1:0]    route_r [ROUTE_LEN];

  logic [HOP_W-1:0]     hop_r;        // next hop to issue a read for
  logic                 pend_r;       // read data of the previous hop is back
  logic                 pend_oor_r;
  logic [LA_W-1:0]      pend_addr_r;
  logic                 ok_r;         // every hop seen so far has a free channel

  // copy of the last table write, for a read issued in the same cycle
  logic                 byp_vld_r;
  logic [LA_W-1:0]      byp_addr_r;
  logic [CAP_W-1:0]     byp_data_r;

  logic [CAP_W-1:0]     capacity_r;
  logic [CAP_W-1:0]     fill_level_r; // value the clearing pass writes into the table
  logic [CLR_W-1:0]     clr_cnt_r;
  logic                 clr_item_r;   // clearing pass belongs to a reinit beat

  logic [CNT_W-1:0]     adm_total_r;
  logic [CNT_W-1:0]     blk_total_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // free channel table and per-connection counters
  logic [CAP_W-1:0]     free_mem [LINKS];
  logic [CAP_W-1:0]     lm_rdata_r;
  lca_conn_cnt_t        conn_mem [CONNECTIONS];
  lca_conn_cnt_t        cm_rdata_r;

  // ---------------------------------------------------------------------------
  // combinational
  // ---------------------------------------------------------------------------
  logic                 accept;
  lca_kind_t            in_kind;
  logic [HOP_W-1:0]     in_hops;
  logic [HOP_W-1:0]     in_hops_clamp;

  logic [LINK_W-1:0]    issue_link;
  logic                 issue_en;
  logic                 issue_oor;
  logic                 phase_done;
  logic                 clr_last;

  logic [CAP_W-1:0]     eff;
  logic [CAP_W:0]       rel_sum;
  logic [CAP_W-1:0]     rel_val;
  logic [CAP_W-1:0]     take_val;

  logic                 lm_re;
  logic [LA_W-1:0]      lm_raddr;
  logic                 lm_we;
  logic [LA_W-1:0]      lm_waddr;
  logic [CAP_W-1:0]     lm_wdata;

  logic                 cm_we;
  logic [CA_W-1:0]      cm_waddr;
  lca_conn_cnt_t        cm_wdata;

  logic                 out_free;
  logic                 count_go;
  logic                 adm_now;
  logic                 blk_now;
  logic                 conn_ok;
  logic [CNT_W-1:0]     adm_total_nxt;
  logic [CNT_W-1:0]     blk_total_nxt;
  lca_conn_cnt_t        cnt_nxt;
  logic [CNT_W:0]       sum_wide;
  logic [CNT_W-1:0]     sum_sat;
  logic [CNT_W-1:0]     rep_adm;
  logic [CNT_W-1:0]     rep_blk;
  logic                 cfg_wr;

  assign in_kind       = lca_kind_t'(in_tuser);
  assign in_hops       = in_tdata[CONN_W +: HOP_W];
  assign in_hops_clamp = (in_hops > HOP_W'(MAX_HOPS)) ? HOP_W'(MAX_HOPS) : in_hops;
  assign accept        = in_tvalid && in_tready;
  assign clr_last      = (clr_cnt_r == CLR_W'(SWEEP - 1));
  assign phase_done    = (hop_r == hops_r) && !pend_r;
  assign out_free      = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_item_r ? ST_COUNT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_ARRIVAL: state_nxt = ST_CHECK;
            KIND_DEPART:  state_nxt = ST_UPDATE;
            KIND_REINIT:  state_nxt = ST_CLEAR;
            KIND_NOP:     state_nxt = ST_COUNT;
            default:      state_nxt = ST_COUNT;
          endcase
        end
      end
      ST_CHECK: begin
        if (phase_done) begin
          state_nxt = ok_r ? ST_UPDATE : ST_COUNT;
        end
      end
      ST_UPDATE: begin
        if (phase_done) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    issue_link = route_r[hop_r[RIDX_W-1:0]];
    issue_en   = ((state_r == ST_CHECK) || (state_r == ST_UPDATE)) && (hop_r < hops_r);
    issue_oor  = (32'(issue_link) >= LINKS);
    lm_re      = issue_en;
    lm_raddr   = LA_W'(issue_link);

    // value of the hop whose read data is back, newest write wins
    eff      = (byp_vld_r && (byp_addr_r == pend_addr_r)) ? byp_data_r : lm_rdata_r;
    rel_sum  = {1'b0, eff} + (CAP_W + 1)'(1);
    rel_val  = (rel_sum > {1'b0, capacity_r}) ? capacity_r : rel_sum[CAP_W-1:0];
    take_val = (eff == '0) ? '0 : eff - CAP_W'(1);

    lm_we    = 1'b0;
    lm_waddr = pend_addr_r;
    lm_wdata = take_val;
    if (state_r == ST_CLEAR) begin
      lm_we    = (32'(clr_cnt_r) < LINKS);
      lm_waddr = LA_W'(clr_cnt_r);
      lm_wdata = fill_level_r;
    end else if ((state_r == ST_UPDATE) && pend_r) begin
      if (kind_r == KIND_ARRIVAL) begin
        lm_we    = 1'b1;
        lm_wdata = take_val;
      end else begin
        lm_we    = !pend_oor_r;
        lm_wdata = rel_val;
      end
    end

    // counters, committed when the result enters the output register
    count_go = (state_r == ST_COUNT) && out_free;
    adm_now  = (kind_r == KIND_ARRIVAL) && ok_r;
    blk_now  = (kind_r == KIND_ARRIVAL) && !ok_r;
    conn_ok  = (32'(conn_r) < CONNECTIONS);

    adm_total_nxt = (adm_now && (adm_total_r != CNT_MAX)) ? adm_total_r + CNT_W'(1)
                                                         : adm_total_r;
    blk_total_nxt = (blk_now && (blk_total_r != CNT_MAX)) ? blk_total_r + CNT_W'(1)
                                                         : blk_total_r;
    cnt_nxt.admitted = (adm_now && (cm_rdata_r.admitted != CNT_MAX))
                       ? cm_rdata_r.admitted + CNT_W'(1) : cm_rdata_r.admitted;
    cnt_nxt.blocked  = (blk_now && (cm_rdata_r.blocked != CNT_MAX))
                       ? cm_rdata_r.blocked + CNT_W'(1) : cm_rdata_r.blocked;

    sum_wide = {1'b0, adm_total_nxt} + {1'b0, blk_total_nxt};
    sum_sat  = sum_wide[CNT_W] ? CNT_MAX : sum_wide[CNT_W-1:0];
    rep_adm  = (conn_ok && (kind_r != KIND_REINIT)) ? cnt_nxt.admitted : '0;
    rep_blk  = (conn_ok && (kind_r != KIND_REINIT)) ? cnt_nxt.blocked  : '0;

    cm_we    = 1'b0;
    cm_waddr = CA_W'(conn_r);
    cm_wdata = cnt_nxt;
    if (state_r == ST_CLEAR) begin
      cm_we    = (32'(clr_cnt_r) < CONNECTIONS);
      cm_waddr = CA_W'(clr_cnt_r);
      cm_wdata = '0;
    end else if (count_go && conn_ok && (kind_r == KIND_ARRIVAL)) begin
      cm_we = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (lm_we) begin
      free_mem[lm_waddr] <= lm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (lm_re) begin
      lm_rdata_r <= free_mem[lm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      conn_mem[cm_waddr] <= cm_wdata;
    end
  end

  // per-connection counters are fetched when the beat is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      cm_rdata_r <= conn_mem[CA_W'(in_tdata[CONN_W-1:0])];
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      hop_r        <= '0;
      pend_r       <= 1'b0;
      ok_r         <= 1'b0;
      byp_vld_r    <= 1'b0;
      fill_level_r <= CAP_RESET;
      clr_cnt_r    <= '0;
      clr_item_r   <= 1'b0;
      adm_total_r  <= '0;
      blk_total_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= issue_en;
      byp_vld_r <= lm_we;

      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      end

      if (accept) begin
        hop_r      <= '0;
        ok_r       <= (in_hops_clamp != '0);
        clr_item_r <= (in_kind == KIND_REINIT);
        if (in_kind == KIND_REINIT) begin
          fill_level_r <= capacity_r;
          clr_cnt_r    <= '0;
          adm_total_r  <= '0;
          blk_total_r  <= '0;
        end
      end else if ((state_r == ST_CHECK) && phase_done) begin
        hop_r <= '0;
      end else if (issue_en) begin
        hop_r <= hop_r + HOP_W'(1);
      end

      // a hop with no free channel or an unknown link blocks the call
      if ((state_r == ST_CHECK) && pend_r && (pend_oor_r || (eff == '0))) begin
        ok_r <= 1'b0;
      end

      if (count_go) begin
        adm_total_r  <= adm_total_nxt;
        blk_total_r  <= blk_total_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // capacity register
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? CFG_DW'(capacity_r) : '0;

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      conn_r <= in_tdata[CONN_W-1:0];
      hops_r <= (in_kind == KIND_ARRIVAL || in_kind == KIND_DEPART) ? in_hops_clamp : '0;
      for (int i = 0; i < ROUTE_LEN; i++) begin
        route_r[i] <= in_tdata[CONN_W + HOP_W + LINK_W*i +: LINK_W];
      end
    end
    if (issue_en) begin
      pend_oor_r  <= issue_oor;
      pend_addr_r <= lm_raddr;
    end
    byp_addr_r <= lm_waddr;
    byp_data_r <= lm_wdata;
    if (count_go) begin
      out_tdata_r <= {7'd0, rep_blk, rep_adm, blk_total_nxt, sum_sat, adm_now};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
